FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL; every use is clocked by clk and
// held off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// If pre holds at an edge, post holds at the next edge.
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: sv/cdc_pkg.sv
`timescale 1ns / 1ps

package cdc_pkg;

  // structure sizes
  localparam int WINDOW_DEPTH    = 64;
  localparam int MAX_BLOCK_BYTES = 65536;

  // fixed field widths
  localparam int BYTE_W     = 8;
  localparam int HASH_W     = 64;
  localparam int PRIME_W    = 32;
  localparam int WL_W       = 7;
  localparam int BLK_W      = 17;
  localparam int MUL_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // derived widths
  localparam int POS_W     = $clog2(WINDOW_DEPTH);
  localparam int WIN_CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int WEXT_W    = (WL_W > WIN_CNT_W) ? WL_W : WIN_CNT_W;
  localparam int LEN_W     = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int LEN_EXT_W = (LEN_W > BLK_W) ? LEN_W : BLK_W;

  // multiply sequencer: six partial products plus one drain step
  localparam int MUL_STEPS = 7;
  localparam int MSTEP_W   = $clog2(MUL_STEPS);

  // bit-serial remainder
  localparam int DIV_STEPS = HASH_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HASH_PRIME   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MULT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_BLOCK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_BLOCK    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BLOCK    = 3'd5;

  // register reset values
  localparam logic [PRIME_W-1:0] RST_HASH_PRIME = 32'd3;
  localparam logic [HASH_W-1:0]  RST_OUT_MULT   = 64'd617673396283947;
  localparam logic [WL_W-1:0]    RST_WINDOW_LEN = 7'd31;
  localparam logic [BLK_W-1:0]   RST_MIN_BLOCK  = 17'd4096;
  localparam logic [BLK_W-1:0]   RST_AVG_BLOCK  = 17'd8192;
  localparam logic [BLK_W-1:0]   RST_MAX_BLOCK  = 17'd16384;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DECIDE,
    ST_DIV,
    ST_OUT
  } cdc_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

FILE: sv/cdc_if.sv
`timescale 1ns / 1ps

// input transaction: data byte or end of file
interface cdc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [cdc_pkg::BYTE_W-1:0]  data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

// result transaction: one per input transaction
interface cdc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        block_done;
  logic [cdc_pkg::BLK_W-1:0]   block_length;
  logic [cdc_pkg::HASH_W-1:0]  block_fingerprint;
  logic                        first_of_file;
  logic                        empty_file;

  modport source (output valid, output block_done, output block_length,
                  output block_fingerprint, output first_of_file,
                  output empty_file, input ready);
  modport sink   (input valid, input block_done, input block_length,
                  input block_fingerprint, input first_of_file,
                  input empty_file, output ready);
endinterface

FILE: sv/cdc_mul.sv
`timescale 1ns / 1ps

// 32x32 unsigned multiplier, product registered
module cdc_mul (
  input  logic                            clk,
  input  logic [cdc_pkg::MUL_W-1:0]       a,
  input  logic [cdc_pkg::MUL_W-1:0]       b,
  output logic [2*cdc_pkg::MUL_W-1:0]     prod
);

  always_ff @(posedge clk) begin
    prod <= {{cdc_pkg::MUL_W{1'b0}}, a} * {{cdc_pkg::MUL_W{1'b0}}, b};
  end

endmodule

FILE: sv/cdc_mod_unit.sv
`timescale 1ns / 1ps

// restoring remainder, one dividend bit per cycle
module cdc_mod_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [cdc_pkg::HASH_W-1:0]     dividend,
  input  logic [cdc_pkg::BLK_W-1:0]      divisor,
  output logic [cdc_pkg::BLK_W-1:0]      rem,
  output cdc_pkg::mod_stat_t             stat
);

  logic                          busy;
  logic                          done;
  logic [cdc_pkg::DCNT_W-1:0]    cnt;
  logic [cdc_pkg::HASH_W-1:0]    dvd;
  logic [cdc_pkg::BLK_W:0]       r2;
  logic [cdc_pkg::BLK_W:0]       diff;
  logic                          ge;

  assign r2   = {rem, dvd[cdc_pkg::HASH_W-1]};
  assign diff = r2 - {1'b0, divisor};
  assign ge   = (r2 >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == cdc_pkg::DCNT_W'(cdc_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[cdc_pkg::HASH_W-2:0], 1'b0};
      rem <= ge ? diff[cdc_pkg::BLK_W-1:0] : r2[cdc_pkg::BLK_W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: sv/content_defined_chunker_unit.sv
`timescale 1ns / 1ps
// Content-defined chunker. Each transaction on items is a data byte
// (kind 0) or an end-of-file mark (kind 1); each yields exactly one
// transaction on results, which flags a finished block with its length,
// 64-bit fingerprint, first-of-file and empty-file marks.
// Configuration: cfg_we/cfg_index/cfg_data write one register per edge;
// the user must write only while the block is idle, which the block
// itself does not enforce. Timing: one transaction at a time,
// items.ready is high only in idle. A data byte runs the seven multiply
// steps (six products through the shared 32x32 multiplier), a decide
// step, the bit-serial remainder unit only when the checksum remainder
// test runs, then the output step; an end-of-file mark goes straight to it.
// Results sit in an output register; items.ready rises again as soon as
// the result is loaded, so the next byte is worked on while the receiver
// stalls. A finished result waits in the last step until the register
// frees up.
// Reset (rst, synchronous) restores the register defaults, clears the
// rolling window (per-entry valid bits), both hashes and the length.
`include "assert_macros.svh"

module content_defined_chunker_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [cdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cdc_pkg::CFG_DATA_W-1:0]     cfg_data,
  cdc_in_if.sink                             items,
  cdc_out_if.source                          results
);

  localparam int HW  = cdc_pkg::HASH_W;
  localparam int MW  = cdc_pkg::MUL_W;
  localparam int BW  = cdc_pkg::BYTE_W;
  localparam int LEW = cdc_pkg::LEN_EXT_W;
  localparam int WEW = cdc_pkg::WEXT_W;

  // configuration registers
  logic [cdc_pkg::PRIME_W-1:0] hash_prime;
  logic [HW-1:0]               outgoing_multiplier;
  logic [cdc_pkg::WL_W-1:0]    window_length;
  logic [cdc_pkg::BLK_W-1:0]   min_block;
  logic [cdc_pkg::BLK_W-1:0]   avg_block;
  logic [cdc_pkg::BLK_W-1:0]   max_block;

  // block state
  cdc_pkg::cdc_state_t           state, state_next;
  logic [cdc_pkg::MSTEP_W-1:0]   mstep;
  logic [cdc_pkg::POS_W-1:0]     pos;
  logic [cdc_pkg::POS_W-1:0]     pos_next;
  logic [HW-1:0]                 ck;
  logic [HW-1:0]                 fp;
  logic [cdc_pkg::LEN_W-1:0]     cur_len;
  logic                          awaiting;
  logic                          seen;
  logic                          cut;
  logic                          is_eof;
  logic [BW-1:0]                 b_reg;

  // rolling window memory
  logic [BW-1:0]                      win [cdc_pkg::WINDOW_DEPTH];
  logic [cdc_pkg::WINDOW_DEPTH-1:0]   win_valid;
  logic [BW-1:0]                      old_raw;
  logic                               old_vld;
  logic [BW-1:0]                      old_byte;

  // shared units
  logic [MW-1:0]                 mul_a, mul_b;
  logic [2*MW-1:0]               prod;
  logic                          mod_start;
  logic [cdc_pkg::BLK_W-1:0]     mod_rem;
  cdc_pkg::mod_stat_t            mod_stat;

  // control strobes
  logic accept, out_free, out_load, win_write;

  // output register
  logic                          out_valid;
  logic                          o_done, o_first, o_empty;
  logic [cdc_pkg::BLK_W-1:0]     o_len;
  logic [HW-1:0]                 o_fp;
  logic                          res_done, res_first, res_empty;
  logic [cdc_pkg::BLK_W-1:0]     res_len;
  logic [HW-1:0]                 res_fp;

  // datapath helpers
  logic [HW-1:0]   b_sext;
  logic [HW-1:0]   corr;
  logic [LEW-1:0]  len_ext;
  logic            len_ge_min, len_eq_max, len_full, force_cut, need_div;
  logic [WEW-1:0]  wl_ext, eff_win, pos_inc;

  assign accept    = items.valid && items.ready;
  assign out_free  = !out_valid || results.ready;
  assign win_write = (state == cdc_pkg::ST_MUL) && (mstep == '0);

  assign b_sext   = {{(HW-BW){b_reg[BW-1]}}, b_reg};
  assign old_byte = old_vld ? old_raw : '0;
  // sign of the leaving byte: old*M = old_u*M - 256*M when negative
  assign corr     = old_byte[BW-1] ? {outgoing_multiplier[HW-BW-1:0], {BW{1'b0}}} : '0;

  assign len_ext    = LEW'(cur_len);
  assign len_ge_min = len_ext >= LEW'(min_block);
  assign len_eq_max = len_ext == LEW'(max_block);
  assign len_full   = len_ext >= LEW'(cdc_pkg::MAX_BLOCK_BYTES);
  assign force_cut  = len_full || (len_ge_min && len_eq_max);
  assign need_div   = !force_cut && len_ge_min && (avg_block != '0);

  // window position advance; bad window lengths fall back to full depth
  assign wl_ext  = WEW'(window_length);
  assign eff_win = ((wl_ext == '0) || (wl_ext > WEW'(cdc_pkg::WINDOW_DEPTH)))
                   ? WEW'(cdc_pkg::WINDOW_DEPTH) : wl_ext;
  assign pos_inc = WEW'(pos) + 1'b1;
  assign pos_next = (pos_inc >= eff_win) ? '0 : cdc_pkg::POS_W'(pos_inc);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_prime          <= cdc_pkg::RST_HASH_PRIME;
      outgoing_multiplier <= cdc_pkg::RST_OUT_MULT;
      window_length       <= cdc_pkg::RST_WINDOW_LEN;
      min_block           <= cdc_pkg::RST_MIN_BLOCK;
      avg_block           <= cdc_pkg::RST_AVG_BLOCK;
      max_block           <= cdc_pkg::RST_MAX_BLOCK;
    end else if (cfg_we) begin
      case (cfg_index)
        cdc_pkg::REG_HASH_PRIME: hash_prime          <= cfg_data[cdc_pkg::PRIME_W-1:0];
        cdc_pkg::REG_OUT_MULT:   outgoing_multiplier <= cfg_data[HW-1:0];
        cdc_pkg::REG_WINDOW_LEN: window_length       <= cfg_data[cdc_pkg::WL_W-1:0];
        cdc_pkg::REG_MIN_BLOCK:  min_block           <= cfg_data[cdc_pkg::BLK_W-1:0];
        cdc_pkg::REG_AVG_BLOCK:  avg_block           <= cfg_data[cdc_pkg::BLK_W-1:0];
        cdc_pkg::REG_MAX_BLOCK:  max_block           <= cfg_data[cdc_pkg::BLK_W-1:0];
        default: ;
      endcase
    end
  end

  // window memory: read the leaving byte and capture the new one on
  // accept, overwrite the window entry in the first multiply step
  always_ff @(posedge clk) begin
    if (accept) begin
      old_raw <= win[pos];
      b_reg   <= items.data_byte;
    end
    if (win_write) begin
      win[pos] <= b_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= '0;
      old_vld   <= 1'b0;
    end else begin
      if (accept) begin
        old_vld <= win_valid[pos];
      end
      if (win_write) begin
        win_valid[pos] <= 1'b1;
      end
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (mstep)
      3'd0:    begin mul_a = fp[MW-1:0];      mul_b = hash_prime; end
      3'd1:    begin mul_a = fp[HW-1:MW];     mul_b = hash_prime; end
      3'd2:    begin mul_a = ck[MW-1:0];      mul_b = hash_prime; end
      3'd3:    begin mul_a = ck[HW-1:MW];     mul_b = hash_prime; end
      3'd4:    begin mul_a = MW'(old_byte);   mul_b = outgoing_multiplier[MW-1:0]; end
      3'd5:    begin mul_a = MW'(old_byte);   mul_b = outgoing_multiplier[HW-1:MW]; end
      default: begin mul_a = '0;              mul_b = '0; end
    endcase
  end

  cdc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  cdc_mod_unit u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (ck),
    .divisor  (avg_block),
    .rem      (mod_rem),
    .stat     (mod_stat)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    items.ready = 1'b0;
    mod_start   = 1'b0;
    out_load    = 1'b0;
    case (state)
      cdc_pkg::ST_IDLE: begin
        items.ready = 1'b1;
        if (items.valid) begin
          state_next = items.kind ? cdc_pkg::ST_OUT : cdc_pkg::ST_MUL;
        end
      end
      cdc_pkg::ST_MUL: begin
        if (mstep == cdc_pkg::MSTEP_W'(cdc_pkg::MUL_STEPS - 1)) begin
          state_next = cdc_pkg::ST_DECIDE;
        end
      end
      cdc_pkg::ST_DECIDE: begin
        mod_start  = need_div;
        state_next = need_div ? cdc_pkg::ST_DIV : cdc_pkg::ST_OUT;
      end
      cdc_pkg::ST_DIV: begin
        if (mod_stat.done) begin
          state_next = cdc_pkg::ST_OUT;
        end
      end
      cdc_pkg::ST_OUT: begin
        out_load = out_free;
        if (out_free) begin
          state_next = cdc_pkg::ST_IDLE;
        end
      end
      default: state_next = cdc_pkg::ST_IDLE;
    endcase
  end

  // hash accumulation and block bookkeeping; product k lands at step k+1
  always_ff @(posedge clk) begin
    if (rst) begin
      mstep    <= '0;
      pos      <= '0;
      ck       <= '0;
      fp       <= '0;
      cur_len  <= '0;
      awaiting <= 1'b1;
      seen     <= 1'b0;
      cut      <= 1'b0;
      is_eof   <= 1'b0;
    end else begin
      if (accept) begin
        mstep  <= '0;
        is_eof <= items.kind;
        cut    <= 1'b0;
      end
      if (state == cdc_pkg::ST_MUL) begin
        mstep <= mstep + 1'b1;
        case (mstep)
          3'd0: begin
            pos     <= pos_next;
            cur_len <= cur_len + 1'b1;
            seen    <= 1'b1;
          end
          3'd1: fp <= prod + b_sext;
          3'd2: fp <= fp + {prod[MW-1:0], {MW{1'b0}}};
          3'd3: ck <= prod + b_sext + corr;
          3'd4: ck <= ck + {prod[MW-1:0], {MW{1'b0}}};
          3'd5: ck <= ck - prod;
          3'd6: ck <= ck - {prod[MW-1:0], {MW{1'b0}}};
          default: ;
        endcase
      end
      if (state == cdc_pkg::ST_DECIDE) begin
        cut <= force_cut;
      end
      if ((state == cdc_pkg::ST_DIV) && mod_stat.done) begin
        cut <= ({{(cdc_pkg::PRIME_W-cdc_pkg::BLK_W){1'b0}}, mod_rem} == hash_prime);
      end
      if (out_load) begin
        if (is_eof) begin
          fp       <= '0;
          cur_len  <= '0;
          awaiting <= 1'b1;
          seen     <= 1'b0;
        end else if (cut) begin
          fp       <= '0;
          cur_len  <= '0;
          awaiting <= 1'b0;
        end
      end
    end
  end

  // result for the transaction in flight
  always_comb begin
    res_done  = 1'b0;
    res_len   = '0;
    res_fp    = '0;
    res_first = 1'b0;
    res_empty = 1'b0;
    if (is_eof) begin
      if (cur_len != '0) begin
        res_done  = 1'b1;
        res_len   = cdc_pkg::BLK_W'(len_ext);
        res_fp    = fp;
        res_first = awaiting;
      end else if (!seen) begin
        res_done  = 1'b1;
        res_first = 1'b1;
        res_empty = 1'b1;
      end
    end else if (cut) begin
      res_done  = 1'b1;
      res_len   = cdc_pkg::BLK_W'(len_ext);
      res_fp    = fp;
      res_first = awaiting;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_done  <= res_done;
      o_len   <= res_len;
      o_fp    <= res_fp;
      o_first <= res_first;
      o_empty <= res_empty;
    end
  end

  assign results.valid             = out_valid;
  assign results.block_done        = o_done;
  assign results.block_length      = o_len;
  assign results.block_fingerprint = o_fp;
  assign results.first_of_file     = o_first;
  assign results.empty_file        = o_empty;

  // checks
  `ASSERT_CLK(a_ready_div_idle, (!items.ready || !mod_stat.busy), "ready while remainder busy")
  `ASSERT_CLK(a_done_in_div, (!mod_stat.done || (state == cdc_pkg::ST_DIV)), "stray remainder done")
  `ASSERT_NEXT(a_block_cleared, (out_load && (is_eof || cut)), (cur_len == '0), "block not cleared after close")
  `ASSERT_CLK(a_len_bound, (len_ext <= LEW'(cdc_pkg::MAX_BLOCK_BYTES)), "block length past buffer size")
  `ASSERT_CLK(a_pos_bound, (32'(pos) < cdc_pkg::WINDOW_DEPTH), "window position out of range")

endmodule

FILE: test/chunk_checker.sv
`timescale 1ns / 1ps

module chunk_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cdc_pkg::CFG_DATA_W-1:0] cfg_data,
  cdc_in_if                              items,
  cdc_out_if                             results,
  output int                             mismatch_count,
  output int                             chunks_outstanding
);

  localparam int BYTE_W          = cdc_pkg::BYTE_W;
  localparam int HASH_W          = cdc_pkg::HASH_W;
  localparam int PRIME_W         = cdc_pkg::PRIME_W;
  localparam int WL_W            = cdc_pkg::WL_W;
  localparam int BLK_W           = cdc_pkg::BLK_W;
  localparam int WINDOW_DEPTH    = cdc_pkg::WINDOW_DEPTH;
  localparam int MAX_BLOCK_BYTES = cdc_pkg::MAX_BLOCK_BYTES;

  typedef struct packed {
    logic              done;
    logic [BLK_W-1:0]  len;
    logic [HASH_W-1:0] fp;
    logic              first;
    logic              empty;
  } chunk_result_t;

  // shadow registers
  logic [PRIME_W-1:0] hash_prime;
  logic [HASH_W-1:0]  out_mult;
  logic [WL_W-1:0]    win_len;
  logic [BLK_W-1:0]   min_blk;
  logic [BLK_W-1:0]   avg_blk;
  logic [BLK_W-1:0]   max_blk;

  // chunker state
  logic [BYTE_W-1:0]  win_bytes [WINDOW_DEPTH];
  int unsigned        win_pos;
  logic [HASH_W-1:0]  win_sum;
  logic [HASH_W-1:0]  block_fp;
  logic [BLK_W-1:0]   block_len;
  logic               first_pending;
  logic               saw_byte;

  chunk_result_t expected_chunks[$];

  function automatic logic [HASH_W-1:0] widen(input logic [BYTE_W-1:0] v);
    return {{(HASH_W-BYTE_W){v[BYTE_W-1]}}, v};
  endfunction

  task automatic report_mismatch(input string what, input logic [HASH_W-1:0] got,
                                 input logic [HASH_W-1:0] want);
    $display("MISMATCH @%0t %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic clear_chunker();
    hash_prime    = cdc_pkg::RST_HASH_PRIME;
    out_mult      = cdc_pkg::RST_OUT_MULT;
    win_len       = cdc_pkg::RST_WINDOW_LEN;
    min_blk       = cdc_pkg::RST_MIN_BLOCK;
    avg_blk       = cdc_pkg::RST_AVG_BLOCK;
    max_blk       = cdc_pkg::RST_MAX_BLOCK;
    for (int i = 0; i < WINDOW_DEPTH; i++) win_bytes[i] = '0;
    win_pos       = 0;
    win_sum       = '0;
    block_fp      = '0;
    block_len     = '0;
    first_pending = 1'b1;
    saw_byte      = 1'b0;
  endtask

  // one input transaction -> the result it must produce
  task automatic advance_chunker(input logic is_eof, input logic [BYTE_W-1:0] raw,
                                 output chunk_result_t r);
    int unsigned       span;
    logic [HASH_W-1:0] incoming;
    logic              cut;
    r = '0;
    if (is_eof) begin
      if (block_len != 0) begin
        r.done  = 1'b1;
        r.len   = block_len;
        r.fp    = block_fp;
        r.first = first_pending;
      end else if (!saw_byte) begin
        r.done  = 1'b1;
        r.first = 1'b1;
        r.empty = 1'b1;
      end
      block_fp      = '0;
      block_len     = '0;
      first_pending = 1'b1;
      saw_byte      = 1'b0;
    end else begin
      // out-of-range window length falls back to the full depth
      span = (win_len == 0 || win_len > WINDOW_DEPTH) ? WINDOW_DEPTH : win_len;
      incoming = widen(raw);
      block_fp = block_fp * HASH_W'(hash_prime) + incoming;
      win_sum  = win_sum * HASH_W'(hash_prime) + incoming
                 - widen(win_bytes[win_pos]) * out_mult;
      win_bytes[win_pos] = raw;
      win_pos = (win_pos + 1 >= span) ? 0 : win_pos + 1;
      block_len++;
      saw_byte = 1'b1;
      cut = 1'b0;
      if (block_len >= min_blk) begin
        if (block_len == max_blk)
          cut = 1'b1;
        else if (avg_blk != 0 && win_sum % HASH_W'(avg_blk) == HASH_W'(hash_prime))
          cut = 1'b1;
      end
      if (block_len >= BLK_W'(MAX_BLOCK_BYTES))
        cut = 1'b1;
      if (cut) begin
        r.done        = 1'b1;
        r.len         = block_len;
        r.fp          = block_fp;
        r.first       = first_pending;
        first_pending = 1'b0;
        block_fp      = '0;
        block_len     = '0;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    chunk_result_t got;
    chunk_result_t want;
    if (rst) begin
      clear_chunker();
      expected_chunks.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cdc_pkg::REG_HASH_PRIME: hash_prime = cfg_data[PRIME_W-1:0];
          cdc_pkg::REG_OUT_MULT:   out_mult   = cfg_data[HASH_W-1:0];
          cdc_pkg::REG_WINDOW_LEN: win_len    = cfg_data[WL_W-1:0];
          cdc_pkg::REG_MIN_BLOCK:  min_blk    = cfg_data[BLK_W-1:0];
          cdc_pkg::REG_AVG_BLOCK:  avg_blk    = cfg_data[BLK_W-1:0];
          cdc_pkg::REG_MAX_BLOCK:  max_blk    = cfg_data[BLK_W-1:0];
          default: ;
        endcase
      end
      if (results.valid && results.ready) begin
        got = {results.block_done, results.block_length, results.block_fingerprint,
               results.first_of_file, results.empty_file};
        if (expected_chunks.size() == 0) begin
          report_mismatch("result with nothing outstanding", got.fp, '0);
        end else begin
          want = expected_chunks.pop_front();
          if (got.done !== want.done)
            report_mismatch("block_done", HASH_W'(got.done), HASH_W'(want.done));
          if (got.len !== want.len)
            report_mismatch("block_length", HASH_W'(got.len), HASH_W'(want.len));
          if (got.fp !== want.fp)
            report_mismatch("block_fingerprint", got.fp, want.fp);
          if (got.first !== want.first)
            report_mismatch("first_of_file", HASH_W'(got.first), HASH_W'(want.first));
          if (got.empty !== want.empty)
            report_mismatch("empty_file", HASH_W'(got.empty), HASH_W'(want.empty));
        end
      end
      if (items.valid && items.ready) begin
        advance_chunker(items.kind, items.data_byte, want);
        expected_chunks.push_back(want);
      end
    end
    chunks_outstanding <= expected_chunks.size();
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int BYTE_W       = cdc_pkg::BYTE_W;
  localparam int HASH_W       = cdc_pkg::HASH_W;
  localparam int PRIME_W      = cdc_pkg::PRIME_W;
  localparam int WL_W         = cdc_pkg::WL_W;
  localparam int BLK_W        = cdc_pkg::BLK_W;
  localparam int CFG_IDX_W    = cdc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W   = cdc_pkg::CFG_DATA_W;
  localparam int WINDOW_DEPTH = cdc_pkg::WINDOW_DEPTH;

  // About 480 transactions with idling, plus the long stall and the drains,
  // all fit under CYCLE_LIMIT.
  localparam int CYCLE_LIMIT     = 200_000;
  localparam int RAND_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int HOLD_OFF_CYCLES = 400;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cdc_in_if  items();
  cdc_out_if results();

  int          fail_count;
  int          pending;
  int unsigned cycle_count = 0;

  // traffic shaping knobs, set by the stimulus only
  bit src_idle_on  = 1'b0;
  bit sink_idle_on = 1'b0;
  int sink_hold_req = 0;

  content_defined_chunker_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items),
    .results   (results)
  );

  chunk_checker i_checker (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .items              (items),
    .results            (results),
    .mismatch_count     (fail_count),
    .chunks_outstanding (pending)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side. A hold request (long stall, in cycles) is served once
  // and wins over the random bursts; with idling off ready stays high.
  initial begin : result_side
    bit hold_done;
    hold_done = 1'b0;
    results.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_req > 0 && !hold_done) begin
        hold_done = 1'b1;
        results.ready <= 1'b0;
        repeat (sink_hold_req) @(posedge clk);
        results.ready <= 1'b1;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        results.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        results.ready <= 1'b1;
      end else begin
        results.ready <= 1'b1;
      end
    end
  end

  // Offer one transaction and hold it until it is taken. valid is left
  // high so back-to-back transactions need no extra assignment.
  task automatic send_item(input logic is_eof, input logic [BYTE_W-1:0] value);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      items.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    items.valid     <= 1'b1;
    items.kind      <= is_eof;
    items.data_byte <= value;
    do @(posedge clk); while (!items.ready);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] value);
    send_item(1'b0, value);
  endtask

  task automatic send_eof();
    send_item(1'b1, '0);
  endtask

  task automatic send_random_byte();
    send_byte(BYTE_W'($urandom_range(0, 255)));
  endtask

  // stop offering and wait until every result transaction has come back
  task automatic drain();
    items.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // registers only change with the unit idle
  task automatic configure(input logic [PRIME_W-1:0] prime, input logic [HASH_W-1:0] mult,
                           input logic [WL_W-1:0] wlen, input logic [BLK_W-1:0] min_len,
                           input logic [BLK_W-1:0] avg_len, input logic [BLK_W-1:0] max_len);
    drain();
    repeat (2) @(posedge clk);
    write_reg(cdc_pkg::REG_HASH_PRIME, CFG_DATA_W'(prime));
    write_reg(cdc_pkg::REG_OUT_MULT,   CFG_DATA_W'(mult));
    write_reg(cdc_pkg::REG_WINDOW_LEN, CFG_DATA_W'(wlen));
    write_reg(cdc_pkg::REG_MIN_BLOCK,  CFG_DATA_W'(min_len));
    write_reg(cdc_pkg::REG_AVG_BLOCK,  CFG_DATA_W'(avg_len));
    write_reg(cdc_pkg::REG_MAX_BLOCK,  CFG_DATA_W'(max_len));
    cfg_we <= 1'b0;
  endtask

  // Small avg/min values keep content-defined cuts frequent; the odd
  // draw pushes a register to its extreme or the window out of range.
  task automatic configure_random();
    logic [PRIME_W-1:0] prime;
    logic [WL_W-1:0]    wlen;
    logic [BLK_W-1:0]   min_len;
    logic [BLK_W-1:0]   avg_len;
    logic [BLK_W-1:0]   max_len;
    case ($urandom_range(0, 4))
      0:       prime = 32'd1;
      1:       prime = 32'd2;
      2:       prime = $urandom_range(1, 7);
      3:       prime = $urandom_range(1, 32'hFFFF_FFFF);
      default: prime = 32'hFFFF_FFFF;
    endcase
    case ($urandom_range(0, 7))
      0:       wlen = '0;
      1:       wlen = WL_W'($urandom_range(65, 127));
      2:       wlen = WL_W'(WINDOW_DEPTH);
      default: wlen = WL_W'($urandom_range(1, WINDOW_DEPTH));
    endcase
    min_len = BLK_W'($urandom_range(0, 16));
    avg_len = ($urandom_range(0, 5) == 0) ? BLK_W'(65536) : BLK_W'($urandom_range(1, 12));
    case ($urandom_range(0, 5))
      0:       max_len = BLK_W'(1);
      1:       max_len = BLK_W'(65536);
      default: max_len = BLK_W'($urandom_range(1, 40));
    endcase
    configure(prime, {$urandom, $urandom}, wlen, min_len, avg_len, max_len);
  endtask

  // mostly bytes with an end of file now and then, so files stay short
  task automatic file_traffic(input int count, input bit pause_midway);
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2)
        drain();
      if ($urandom_range(0, 15) == 0)
        send_eof();
      else
        send_random_byte();
    end
  endtask

  initial begin : stimulus
    items.valid     = 1'b0;
    items.kind      = 1'b0;
    items.data_byte = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: empty files, sign extremes, then a leftover block
    // that is still the first of its file.
    send_eof();
    send_eof();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h01);
    send_eof();

    // Cut forced at length 3 with no checksum test; the trailing end of
    // file finds nothing left, then an empty file follows.
    configure(32'd1, '0, 7'd1, 17'd0, 17'd0, 17'd3);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h00);
    send_byte(8'h7F);
    send_eof();
    send_eof();

    // registers at their largest in-range values: nothing cuts before end of file
    configure(32'hFFFF_FFFF, '1, WL_W'(WINDOW_DEPTH), BLK_W'(65536), BLK_W'(65536),
              BLK_W'(65536));
    repeat (5) send_random_byte();
    send_eof();

    // zero window length acts as the full depth; checksum cuts are likely
    configure(32'd2, {$urandom, $urandom}, 7'd0, 17'd1, 17'd3, BLK_W'(65536));
    repeat (4) send_random_byte();
    send_eof();

    // Random phases. The first one stalls the result side for a long
    // stretch while transactions keep coming; the second drains midway.
    for (int p = 0; p < RAND_PHASES - 1; p++) begin
      configure_random();
      src_idle_on  = (p == 0) ? 1'b1 : bit'($urandom_range(0, 1));
      sink_idle_on = (p == 0) ? 1'b1 : bit'($urandom_range(0, 1));
      if (p == 0) begin
        file_traffic(20, 1'b0);
        sink_hold_req = HOLD_OFF_CYCLES;
        file_traffic(ITEMS_PER_PHASE - 20, 1'b0);
      end else begin
        file_traffic(ITEMS_PER_PHASE, p == 1);
      end
    end

    // last stretch runs without idling on either side
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    configure_random();
    file_traffic(ITEMS_PER_PHASE, 1'b0);

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/cdc_pkg.sv
sv/cdc_if.sv
sv/cdc_mul.sv
sv/cdc_mod_unit.sv
sv/content_defined_chunker_unit.sv
test/chunk_checker.sv
test/testbench.sv
